// ===== rtl/sseg_pkg.sv =====
// ----------------------------------------------------------------------------
// sseg_pkg
// types, codes and constants shared by the display command encoder
// ----------------------------------------------------------------------------
package sseg_pkg;

    localparam int DIGITS_DEFAULT = 4;
    localparam int VAL_W          = 14;
    localparam int CONV_CNT_W     = $clog2(VAL_W + 1);
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);

    localparam logic [VAL_W-1:0] LIMIT_RESET  = 14'd9999;
    localparam logic [3:0]       BRIGHT_MAX   = 4'd15;
    localparam logic [3:0]       BRIGHT_RESET = 4'd15;
    localparam logic [3:0]       BLANK_CODE   = 4'd15;

    localparam logic [3:0] ADDR_NOOP      = 4'd0;
    localparam logic [3:0] ADDR_DIGIT1    = 4'd1;
    localparam logic [3:0] ADDR_DECODE    = 4'd9;
    localparam logic [3:0] ADDR_INTENSITY = 4'd10;
    localparam logic [3:0] ADDR_SCAN      = 4'd11;
    localparam logic [3:0] ADDR_SHUTDOWN  = 4'd12;
    localparam logic [3:0] ADDR_TEST      = 4'd15;

    localparam logic [7:0] DATA_OFF        = 8'h00;
    localparam logic [7:0] DATA_ON         = 8'h01;
    localparam logic [7:0] DATA_DECODE_ALL = 8'hFF;

    typedef enum logic [3:0] {
        CMD_INIT      = 4'd0,
        CMD_SET_VALUE = 4'd1,
        CMD_INTENSITY = 4'd2,
        CMD_TEST_ON   = 4'd3,
        CMD_TEST_OFF  = 4'd4,
        CMD_BLANK     = 4'd5,
        CMD_RESTORE   = 4'd6,
        CMD_SHUTDOWN  = 4'd7,
        CMD_WAKE      = 4'd8,
        CMD_QUERY     = 4'd9
    } cmd_t;

    typedef struct packed {
        cmd_t             kind;
        logic [VAL_W-1:0] value;
        logic [3:0]       bright;
    } q_entry_t;

    typedef struct packed {
        logic [3:0]       addr;
        logic [7:0]       data;
        logic             last;
        logic [VAL_W-1:0] shown;
    } wr_t;

    function automatic longint pow10(input int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++) p = p * 10;
        return p;
    endfunction

endpackage

// ===== rtl/sseg_front.sv =====
// ----------------------------------------------------------------------------
// sseg_front
// accepts commands, keeps value and brightness, queues known commands
// ----------------------------------------------------------------------------
module sseg_front #(
    parameter int DIGITS = sseg_pkg::DIGITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [3:0]                 action,
    input  logic [15:0]                value,
    input  logic [7:0]                 level,
    input  logic [sseg_pkg::VAL_W-1:0] value_limit,
    input  logic                       full,
    output logic                       push,
    output sseg_pkg::q_entry_t         entry
);
    import sseg_pkg::*;

    localparam logic [31:0] DMAX = 32'(pow10(DIGITS) - 1);

    logic [VAL_W-1:0] value_reg, value_next;
    logic [3:0]       bright_reg, bright_next;
    logic [VAL_W-1:0] lim;
    logic [VAL_W-1:0] clamped;
    logic             is_cmd;

    assign s_ready = !full;
    assign is_cmd  = action inside {[CMD_INIT:CMD_QUERY]};
    assign push    = s_valid && !full && is_cmd;

    assign lim     = ({{(32-VAL_W){1'b0}}, value_limit} > DMAX) ? DMAX[VAL_W-1:0]
                                                                : value_limit;
    assign clamped = (value > {{(16-VAL_W){1'b0}}, lim}) ? lim : value[VAL_W-1:0];

    always_comb
    begin
        value_next  = value_reg;
        bright_next = bright_reg;
        case (cmd_t'(action))
            CMD_INIT:      value_next = '0;
            CMD_SET_VALUE: value_next = clamped;
            CMD_INTENSITY: bright_next = (level > {4'b0, BRIGHT_MAX}) ? BRIGHT_MAX
                                                                      : level[3:0];
            default:       ;
        endcase
    end

    assign entry = '{kind: cmd_t'(action), value: value_next, bright: bright_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg  <= '0;
            bright_reg <= BRIGHT_RESET;
        end
        else if (push)
        begin
            value_reg  <= value_next;
            bright_reg <= bright_next;
        end
    end

endmodule

// ===== rtl/sseg_fifo.sv =====
// ----------------------------------------------------------------------------
// sseg_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module sseg_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sseg_pkg::q_entry_t din,
    output logic               full,
    input  logic               pop,
    output logic               nonempty,
    output sseg_pkg::q_entry_t dout
);
    import sseg_pkg::*;

    q_entry_t              mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;

    assign full     = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign nonempty = (count_reg != '0);
    assign dout     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/sseg_bcd.sv =====
// ----------------------------------------------------------------------------
// sseg_bcd
// shift-and-add-3 binary to bcd converter, one bit per cycle
// ----------------------------------------------------------------------------
module sseg_bcd #(
    parameter int DIGITS = sseg_pkg::DIGITS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sseg_pkg::VAL_W-1:0] value,
    output logic                       done,
    output logic [DIGITS*4-1:0]        bcd
);
    import sseg_pkg::*;

    localparam int BCD_W = DIGITS * 4;

    logic [VAL_W-1:0]      bin_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [CONV_CNT_W-1:0] cnt_reg;
    logic [BCD_W-1:0]      adj;

    assign done = (cnt_reg == '0);
    assign bcd  = bcd_reg;

    always_comb
    begin
        adj = bcd_reg;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (adj[i*4 +: 4] >= 4'd5)
                adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (!done)
        begin
            bin_reg <= {bin_reg[VAL_W-2:0], 1'b0};
            bcd_reg <= {adj[BCD_W-2:0], bin_reg[VAL_W-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= CONV_CNT_W'(VAL_W);
        else if (!done)
            cnt_reg <= cnt_reg - 1'b1;
    end

endmodule

// ===== rtl/sseg_back.sv =====
// ----------------------------------------------------------------------------
// sseg_back
// turns queued commands into driver register words
// ----------------------------------------------------------------------------
module sseg_back #(
    parameter int DIGITS = sseg_pkg::DIGITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  sseg_pkg::q_entry_t q_entry,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output sseg_pkg::wr_t      m_word
);
    import sseg_pkg::*;

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(DIGITS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PRE   = 4'b0010,
        S_DIG   = 4'b0100,
        S_BLANK = 4'b1000
    } state_t;

    function automatic logic [2:0] pre_len(input cmd_t k);
        logic [2:0] n;
        case (k)
            CMD_INIT:                   n = 3'd5;
            CMD_SET_VALUE, CMD_RESTORE,
            CMD_BLANK:                  n = 3'd0;
            default:                    n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic has_val(input cmd_t k);
        logic h;
        case (k)
            CMD_INIT, CMD_SET_VALUE, CMD_TEST_OFF,
            CMD_RESTORE, CMD_WAKE:      h = 1'b1;
            default:                    h = 1'b0;
        endcase
        return h;
    endfunction

    function automatic logic [11:0] pre_word(input cmd_t k, input logic [2:0] i,
                                             input logic [3:0] b);
        logic [11:0] w;
        case (k)
            CMD_INIT:
            begin
                case (i)
                    3'd0:    w = {ADDR_TEST, DATA_OFF};
                    3'd1:    w = {ADDR_SHUTDOWN, DATA_ON};
                    3'd2:    w = {ADDR_SCAN, 8'(DIGITS - 1)};
                    3'd3:    w = {ADDR_DECODE, DATA_DECODE_ALL};
                    default: w = {ADDR_INTENSITY, 4'b0, b};
                endcase
            end
            CMD_INTENSITY: w = {ADDR_INTENSITY, 4'b0, b};
            CMD_TEST_ON:   w = {ADDR_TEST, DATA_ON};
            CMD_TEST_OFF:  w = {ADDR_TEST, DATA_OFF};
            CMD_SHUTDOWN:  w = {ADDR_SHUTDOWN, DATA_OFF};
            CMD_WAKE:      w = {ADDR_SHUTDOWN, DATA_ON};
            default:       w = {ADDR_NOOP, DATA_OFF};
        endcase
        return w;
    endfunction

    state_t           state_reg, state_next;
    cmd_t             kind_reg, kind_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [3:0]       bright_reg, bright_next;
    logic [2:0]       pre_idx_reg, pre_idx_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             lead_reg, lead_next;
    logic             out_valid_reg, out_valid_next;
    wr_t              out_reg, out_next;

    logic             out_free;
    logic             emit;
    logic [11:0]      word;
    logic             word_last;
    logic             conv_done;
    logic [DIGITS*4-1:0] conv_bcd;
    logic [3:0]       dig;
    logic [11:0]      pw;
    logic             pre_end;

    sseg_bcd #(
        .DIGITS (DIGITS)
    ) u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (q_pop),
        .value (q_entry.value),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign dig      = conv_bcd[idx_reg*4 +: 4];
    assign pw       = pre_word(kind_reg, pre_idx_reg, bright_reg);
    assign pre_end  = (pre_idx_reg == pre_len(kind_reg) - 3'd1);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        bright_next    = bright_reg;
        pre_idx_next   = pre_idx_reg;
        idx_next       = idx_reg;
        lead_next      = lead_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        emit           = 1'b0;
        word           = '0;
        word_last      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    kind_next    = q_entry.kind;
                    value_next   = q_entry.value;
                    bright_next  = q_entry.bright;
                    pre_idx_next = '0;
                    lead_next    = 1'b1;
                    if (q_entry.kind == CMD_BLANK)
                    begin
                        state_next = S_BLANK;
                        idx_next   = '0;
                    end
                    else if (pre_len(q_entry.kind) != 3'd0)
                        state_next = S_PRE;
                    else
                    begin
                        state_next = S_DIG;
                        idx_next   = IDX_TOP;
                    end
                end
            end
            S_PRE:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    word      = pw;
                    word_last = pre_end && !has_val(kind_reg);
                    if (pre_end)
                    begin
                        if (has_val(kind_reg))
                        begin
                            state_next = S_DIG;
                            idx_next   = IDX_TOP;
                            lead_next  = 1'b1;
                        end
                        else
                            state_next = S_IDLE;
                    end
                    else
                        pre_idx_next = pre_idx_reg + 3'd1;
                end
            end
            S_DIG:
            begin
                if (out_free && conv_done)
                begin
                    emit      = 1'b1;
                    word_last = (idx_reg == '0);
                    if (lead_reg && dig == 4'd0 && idx_reg != '0)
                        word = {4'(idx_reg) + ADDR_DIGIT1, 4'b0, BLANK_CODE};
                    else
                        word = {4'(idx_reg) + ADDR_DIGIT1, 4'b0, dig};
                    lead_next = lead_reg && (dig == 4'd0);
                    if (idx_reg == '0)
                        state_next = S_IDLE;
                    else
                        idx_next = idx_reg - 1'b1;
                end
            end
            S_BLANK:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    word      = {4'(idx_reg) + ADDR_DIGIT1, 4'b0, BLANK_CODE};
                    word_last = (idx_reg == IDX_TOP);
                    if (idx_reg == IDX_TOP)
                        state_next = S_IDLE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = '{addr: word[11:8], data: word[7:0], last: word_last,
                               shown: value_reg};
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        bright_reg  <= bright_next;
        pre_idx_reg <= pre_idx_next;
        idx_reg     <= idx_next;
        lead_reg    <= lead_next;
        out_reg     <= out_next;
    end

endmodule

// ===== rtl/seven_segment_display_command_encoder.sv =====
// ----------------------------------------------------------------------------
// seven_segment_display_command_encoder
// turns display commands into register words for a bcd-decoding led driver
//
// commands arrive on the s_ stream (action in tuser, value and level in
// tdata); every command word with an unknown action is taken and dropped.
// the driver register words leave on the m_ stream, tlast on the final
// word of a command. value_limit is written over the apb-style port.
// a command is taken at once while the four-entry queue has room; the back
// end pops it when idle. digit words of a command with a value sequence
// wait for the binary to bcd converter started at the pop; other words
// follow one per cycle while the m_ side takes them. the first word of a
// command without value sequence passes the queue, the back end state and
// output registers. a stalled m_ side holds its word, fills the queue and
// then drops s_tready. reset empties the queue, clears the stored value
// and sets brightness to 15 and value_limit to 9999.
// ----------------------------------------------------------------------------
module seven_segment_display_command_encoder #(
    parameter int DIGITS = sseg_pkg::DIGITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // value[15:0], level[23:16]
    input  logic [3:0]  s_tuser,   // action[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // reg_addr[3:0], reg_data[11:4], shown_value[25:12]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sseg_pkg::*;

    logic [VAL_W-1:0] limit_reg;
    logic             push;
    logic             full;
    logic             pop;
    logic             nonempty;
    q_entry_t         f_entry;
    q_entry_t         q_entry;
    wr_t              word;

    assign pready = 1'b1;
    assign prdata = {{(32-VAL_W){1'b0}}, limit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (psel && penable && pwrite && pready && !paddr[2])
            limit_reg <= pwdata[VAL_W-1:0];
    end

    sseg_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .action      (s_tuser),
        .value       (s_tdata[15:0]),
        .level       (s_tdata[23:16]),
        .value_limit (limit_reg),
        .full        (full),
        .push        (push),
        .entry       (f_entry)
    );

    sseg_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .din      (f_entry),
        .full     (full),
        .pop      (pop),
        .nonempty (nonempty),
        .dout     (q_entry)
    );

    sseg_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (nonempty),
        .q_entry (q_entry),
        .q_pop   (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_word  (word)
    );

    assign m_tdata = {{(32-12-VAL_W){1'b0}}, word.shown, word.data, word.addr};
    assign m_tlast = word.last;

endmodule
